>>> rtl/core/zzbr_pkg.sv
package zzbr_pkg;

    localparam int BLOCK_SIZE_DEF = 8;
    localparam int SAMPLE_W       = 32;
    localparam int POS_W          = 3;

    typedef enum logic [1:0] {
        HEAD_OTHER     = 2'd0,
        HEAD_DOWN_LEFT = 2'd1,
        HEAD_UP_RIGHT  = 2'd2
    } heading_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } zzbr_cmd_t;

    typedef struct packed {
        logic load_full;
        logic scan_end;
    } zzbr_sts_t;

endpackage

>>> rtl/core/zzbr_ram.sv
module zzbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/zzbr_ctrl.sv
module zzbr_ctrl
    import zzbr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  zzbr_sts_t sts,
    output zzbr_cmd_t cmd,
    output logic      busy
);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.wr     = 1'b0;
        cmd.rd     = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.wr = start;
                if (start && sts.load_full)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd = 1'b1;
                if (sts.scan_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_SCAN);

endmodule

>>> rtl/core/zzbr_path.sv
module zzbr_path
    import zzbr_pkg::*;
#(
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  zzbr_cmd_t           cmd,
    output zzbr_sts_t           sts,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                strobe,
    output logic [SAMPLE_W-1:0] value,
    output logic [POS_W-1:0]    row,
    output logic [POS_W-1:0]    col,
    output logic                last
);

    localparam int ELEMS  = BLOCK_SIZE * BLOCK_SIZE;
    localparam int ADDR_W = $clog2(ELEMS);
    localparam int IDX_W  = $clog2(BLOCK_SIZE);

    localparam logic [IDX_W-1:0]  IDX_MAX  = IDX_W'(BLOCK_SIZE - 1);
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(ELEMS - 1);

    logic [ADDR_W-1:0] load_count_reg;
    logic [ADDR_W-1:0] load_count_next;
    logic [IDX_W-1:0]  scan_row_reg;
    logic [IDX_W-1:0]  scan_row_next;
    logic [IDX_W-1:0]  scan_col_reg;
    logic [IDX_W-1:0]  scan_col_next;
    heading_t          heading_reg;
    heading_t          heading_next;
    logic              strobe_reg;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              at_end;
    logic [IDX_W-1:0]  adv_row;
    logic [IDX_W-1:0]  adv_col;
    heading_t          adv_heading;

    assign at_end = (scan_row_reg == IDX_MAX) && (scan_col_reg == IDX_MAX);
    assign rd_addr = ADDR_W'(ADDR_W'(scan_row_reg) * ADDR_W'(BLOCK_SIZE)
                             + ADDR_W'(scan_col_reg));

    assign sts.load_full = (load_count_reg == ADDR_MAX);
    assign sts.scan_end  = at_end;

    // Next zigzag position: edge turns first, then continue along the diagonal.
    always_comb
    begin
        adv_row     = scan_row_reg;
        adv_col     = scan_col_reg;
        adv_heading = heading_reg;
        priority if (scan_row_reg == '0)
        begin
            if (!scan_col_reg[0])
            begin
                adv_col     = scan_col_reg + 1'b1;
                adv_heading = HEAD_OTHER;
            end
            else
            begin
                adv_row     = scan_row_reg + 1'b1;
                adv_col     = scan_col_reg - 1'b1;
                adv_heading = HEAD_DOWN_LEFT;
            end
        end
        else if ((scan_col_reg == '0) && !scan_row_reg[0])
        begin
            adv_row     = scan_row_reg - 1'b1;
            adv_col     = scan_col_reg + 1'b1;
            adv_heading = HEAD_UP_RIGHT;
        end
        else if (scan_row_reg == IDX_MAX)
        begin
            if (!scan_col_reg[0])
            begin
                adv_heading = HEAD_OTHER;
            end
            else
            begin
                adv_row     = scan_row_reg - 1'b1;
                adv_heading = HEAD_UP_RIGHT;
            end
            adv_col = scan_col_reg + 1'b1;
        end
        else if (scan_col_reg == IDX_MAX)
        begin
            if (scan_row_reg[0])
            begin
                adv_heading = HEAD_OTHER;
            end
            else
            begin
                adv_col     = scan_col_reg - 1'b1;
                adv_heading = HEAD_DOWN_LEFT;
            end
            adv_row = scan_row_reg + 1'b1;
        end
        else if (scan_col_reg == '0)
        begin
            adv_row     = scan_row_reg + 1'b1;
            adv_heading = HEAD_OTHER;
        end
        else if (heading_reg == HEAD_UP_RIGHT)
        begin
            adv_row = scan_row_reg - 1'b1;
            adv_col = scan_col_reg + 1'b1;
        end
        else if (heading_reg == HEAD_DOWN_LEFT)
        begin
            adv_row = scan_row_reg + 1'b1;
            adv_col = scan_col_reg - 1'b1;
        end
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        scan_row_next   = scan_row_reg;
        scan_col_next   = scan_col_reg;
        heading_next    = heading_reg;
        if (cmd.wr)
        begin
            load_count_next = sts.load_full ? '0 : load_count_reg + 1'b1;
        end
        if (cmd.rd)
        begin
            if (at_end)
            begin
                scan_row_next = '0;
                scan_col_next = '0;
                heading_next  = HEAD_OTHER;
            end
            else
            begin
                scan_row_next = adv_row;
                scan_col_next = adv_col;
                heading_next  = adv_heading;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            heading_reg    <= HEAD_OTHER;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            scan_row_reg   <= scan_row_next;
            scan_col_reg   <= scan_col_next;
            heading_reg    <= heading_next;
            strobe_reg     <= cmd.rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            row_reg  <= scan_row_reg;
            col_reg  <= scan_col_reg;
            last_reg <= at_end;
        end
    end

    zzbr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (ELEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr),
        .wr_addr (load_count_reg),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (value)
    );

    assign strobe = strobe_reg;
    assign row    = POS_W'(row_reg);
    assign col    = POS_W'(col_reg);
    assign last   = last_reg;

endmodule

>>> rtl/core/zigzag_block_reorder_core.sv
// Channel   Signals                     Transfer
// input     start, busy, sample         rising edge with start high and busy low
// result    strobe, value, row, col,    one cycle per result while strobe is high,
//           last                        taken at the edge that ends the cycle
//
// A block is loaded with one word per cycle while start is high,
// BLOCK_SIZE*BLOCK_SIZE words. After the last word, busy is high while the
// zigzag walk reads the store, one element per cycle through the RAM read port.
// Each result leaves in the cycle after its read. Reset returns the walk and
// the load count to the start of a block. The receiver cannot stall; loading
// of the next block may begin as the last result leaves.
module zigzag_block_reorder_core
    import zzbr_pkg::*;
#(
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                strobe,
    output logic [SAMPLE_W-1:0] value,
    output logic [POS_W-1:0]    row,
    output logic [POS_W-1:0]    col,
    output logic                last
);

    zzbr_cmd_t cmd;
    zzbr_sts_t sts;

    zzbr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    zzbr_path #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_path (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .sample (sample),
        .strobe (strobe),
        .value  (value),
        .row    (row),
        .col    (col),
        .last   (last)
    );

endmodule
